/* src/efp_pkg.sv */
// Shared types and constants for the escape-time fractal pixel core.
// Used by the register bank, controller, datapath and top level.
package efp_pkg;

  localparam int PIX_W   = 12;
  localparam int D_W     = 14;
  localparam int STEP_W  = 31;
  localparam int WORD_W  = 32;
  localparam int LIMIT_W = 7;
  localparam int COUNT_W = 8;
  localparam int IDX_W   = 2;

  localparam logic [IDX_W-1:0] REG_STEP_SIZE   = 2'd0;
  localparam logic [IDX_W-1:0] REG_OFFSET_REAL = 2'd1;
  localparam logic [IDX_W-1:0] REG_OFFSET_IMAG = 2'd2;
  localparam logic [IDX_W-1:0] REG_ITER_LIMIT  = 2'd3;

  localparam logic [STEP_W-1:0]  STEP_RESET  = 31'd1073742;
  localparam logic [WORD_W-1:0]  OFF_RE_RESET = 32'hF4CC_CCCD;
  localparam logic [WORD_W-1:0]  OFF_IM_RESET = 32'h0000_0000;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET  = 7'd127;

  typedef struct packed {
    logic [STEP_W-1:0]         step_size;
    logic signed [WORD_W-1:0]  offset_real;
    logic signed [WORD_W-1:0]  offset_imag;
    logic [LIMIT_W-1:0]        iteration_limit;
  } efp_cfg_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic map_mul;
    logic map_add;
    logic iter_mul;
    logic iter_eval;
  } efp_cmd_t;

  // Status from the datapath, valid while iter_eval is issued.
  typedef struct packed {
    logic stop;
    logic hit;
  } efp_sts_t;

  typedef struct packed {
    logic [7:0]         blue;
    logic [7:0]         green;
    logic [7:0]         red;
    logic               in_set;
    logic [LIMIT_W-1:0] iter_count;
  } efp_res_t;

  // Clamp a wide signed value to the signed 32-bit range.
  function automatic logic signed [WORD_W-1:0] sat32(input logic signed [65:0] v);
    logic signed [WORD_W-1:0] r;
    if (v > 66'sd2147483647) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -66'sd2147483648) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[WORD_W-1:0];
    end
    return r;
  endfunction

endpackage

/* src/escape_time_fractal_pixel_core.sv */
// Top level of the escape-time fractal pixel core: register bank, controller,
// datapath and output register. Depends on efp_pkg and the efp_* modules.
//
//   Channel  | Direction | Handshake              | Word
//   s_axis   | in        | tvalid/tready          | pixel_col, pixel_row
//   m_axis   | out       | tvalid/tready          | iter_count, in_set, red, green, blue
//   cfg      | in        | cfg_we_i (no wait)     | register index and value
//
// A pixel goes from acceptance through the mapping multiply and add and n steps to the output
// register, where n is the number of steps taken (at most iteration_limit + 1); each step
// forms the three 32x32 products in one state and compares and updates in the next.
// One pixel is in work at a time; the next is taken once the result is in the
// output register. Reset clears the state machine and output valid; config takes reset values.
// A stalled output holds its word; a finished pixel waits until the register frees.
module escape_time_fractal_pixel_core
  import efp_pkg::*;
#(
  parameter int IMG_WIDTH  = 1000,
  parameter int IMG_HEIGHT = 600,
  parameter int FRAC_BITS  = 28
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [23:0]       s_axis_tdata,   // pixel_col[11:0], pixel_row[23:12]
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [31:0]       m_axis_tdata,   // iter_count[6:0], in_set[7], red[15:8],
                                            // green[23:16], blue[31:24]
  input  logic              cfg_we_i,
  input  logic [IDX_W-1:0]  cfg_idx_i,
  input  logic [WORD_W-1:0] cfg_wdata_i
);

  efp_cfg_t cfg;
  efp_cmd_t cmd;
  efp_sts_t sts;
  efp_res_t res;
  logic     out_load, out_free;
  logic     out_valid_q;
  logic [31:0] out_data_q;

  efp_cfg_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (cfg_we_i),
    .idx_i   (cfg_idx_i),
    .wdata_i (cfg_wdata_i),
    .cfg_o   (cfg)
  );

  efp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .out_free_i (out_free),
    .out_load_o (out_load),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  efp_dpath #(
    .IMG_WIDTH  (IMG_WIDTH),
    .IMG_HEIGHT (IMG_HEIGHT),
    .FRAC_BITS  (FRAC_BITS)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .pixel_col_i (s_axis_tdata[11:0]),
    .pixel_row_i (s_axis_tdata[23:12]),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .res_o       (res)
  );

  assign out_free = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q <= {res.blue, res.green, res.red, res.in_set, res.iter_count};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

/* src/efp_cfg_regs.sv */
// Configuration register bank of the fractal pixel core.
// Depends on efp_pkg for register indexes, reset values and the config struct.
module efp_cfg_regs
  import efp_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              we_i,
  input  logic [IDX_W-1:0]  idx_i,
  input  logic [WORD_W-1:0] wdata_i,
  output efp_cfg_t          cfg_o
);

  efp_cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.step_size       <= STEP_RESET;
      cfg_q.offset_real     <= OFF_RE_RESET;
      cfg_q.offset_imag     <= OFF_IM_RESET;
      cfg_q.iteration_limit <= LIMIT_RESET;
    end else if (we_i) begin
      unique case (idx_i)
        REG_STEP_SIZE:   cfg_q.step_size       <= wdata_i[STEP_W-1:0];
        REG_OFFSET_REAL: cfg_q.offset_real     <= wdata_i;
        REG_OFFSET_IMAG: cfg_q.offset_imag     <= wdata_i;
        REG_ITER_LIMIT:  cfg_q.iteration_limit <= wdata_i[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* src/efp_ctrl.sv */
// Sequencing state machine of the fractal pixel core.
// Depends on efp_pkg for the command and status structs.
module efp_ctrl
  import efp_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  logic     out_free_i,
  output logic     out_load_o,
  input  efp_sts_t sts_i,
  output efp_cmd_t cmd_o
);

  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_MAP_MUL = 3'd1;
  localparam logic [2:0] ST_MAP_ADD = 3'd2;
  localparam logic [2:0] ST_MUL     = 3'd3;
  localparam logic [2:0] ST_EVAL    = 3'd4;
  localparam logic [2:0] ST_FIN     = 3'd5;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    out_load_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o  = 1'b1;
        cmd_o.capture = in_valid_i;
        if (in_valid_i) state_d = ST_MAP_MUL;
      end
      ST_MAP_MUL: begin
        cmd_o.map_mul = 1'b1;
        state_d       = ST_MAP_ADD;
      end
      ST_MAP_ADD: begin
        cmd_o.map_add = 1'b1;
        state_d       = ST_MUL;
      end
      ST_MUL: begin
        cmd_o.iter_mul = 1'b1;
        state_d        = ST_EVAL;
      end
      ST_EVAL: begin
        cmd_o.iter_eval = 1'b1;
        state_d = (sts_i.stop || sts_i.hit) ? ST_FIN : ST_MUL;
      end
      ST_FIN: begin
        // Wait here while the previous word still sits in the output register.
        out_load_o = out_free_i;
        if (out_free_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* src/efp_dpath.sv */
// Datapath of the fractal pixel core: coordinate mapping, z = z^2 + c step,
// escape test and palette. Depends on efp_pkg for structs and sat32.
module efp_dpath
  import efp_pkg::*;
#(
  parameter int IMG_WIDTH  = 1000,
  parameter int IMG_HEIGHT = 600,
  parameter int FRAC_BITS  = 28
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  efp_cfg_t         cfg_i,
  input  logic [PIX_W-1:0] pixel_col_i,
  input  logic [PIX_W-1:0] pixel_row_i,
  input  efp_cmd_t         cmd_i,
  output efp_sts_t         sts_o,
  output efp_res_t         res_o
);

  localparam int ESC_SHIFT = 2 * FRAC_BITS + 2;
  localparam bit ESC_OK    = (ESC_SHIFT <= 63);
  localparam logic [63:0] ESC_BOUND = ESC_OK ? (64'd1 << ESC_SHIFT) : 64'd0;
  localparam int MP_W = D_W + WORD_W;

  localparam logic signed [D_W-1:0] SIZE_RE = D_W'(IMG_WIDTH);
  localparam logic signed [D_W-1:0] SIZE_IM = D_W'(IMG_HEIGHT);

  logic signed [D_W-1:0]    d_re_q, d_im_q;
  logic signed [MP_W-1:0]   p_re_q, p_im_q;
  logic signed [WORD_W-1:0] c_re_q, c_im_q, zr_q, zi_q;
  logic signed [63:0]       rr_q, ii_q, ri_q;
  logic [COUNT_W-1:0]       count_q;
  logic                     inside_q;

  logic signed [WORD_W-1:0] step_s;
  logic signed [MP_W-1:0]   h_re, h_im;
  logic signed [WORD_W-1:0] c_re_d, c_im_d;
  logic signed [63:0]       diff, re_sh, ri_sh;
  logic signed [WORD_W-1:0] nr, ni;
  logic [63:0]              mag;
  logic                     escaped, over_limit, in_set;

  assign step_s = $signed({1'b0, cfg_i.step_size});

  // Halving with floor, then offset and saturation.
  assign h_re   = p_re_q >>> 1;
  assign h_im   = p_im_q >>> 1;
  assign c_re_d = sat32(66'(h_re) + 66'(cfg_i.offset_real));
  assign c_im_d = sat32(66'(h_im) + 66'(cfg_i.offset_imag));

  assign diff  = rr_q - ii_q;
  assign re_sh = diff >>> FRAC_BITS;
  assign ri_sh = ri_q >>> (FRAC_BITS - 1);
  assign nr    = sat32(66'(re_sh) + 66'(c_re_q));
  assign ni    = sat32(66'(ri_sh) + 66'(c_im_q));

  // Squares are non-negative, so their unsigned sum is exact in 64 bits.
  assign mag        = $unsigned(rr_q) + $unsigned(ii_q);
  assign escaped    = ESC_OK && (mag > ESC_BOUND);
  assign over_limit = count_q > {1'b0, cfg_i.iteration_limit};

  assign sts_o.stop = escaped || over_limit;
  assign sts_o.hit  = !(escaped || over_limit) && (nr == c_re_q) && (ni == c_im_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      d_re_q <= $signed({1'b0, pixel_col_i, 1'b0}) - SIZE_RE;
      d_im_q <= $signed({1'b0, pixel_row_i, 1'b0}) - SIZE_IM;
    end
    if (cmd_i.map_mul) begin
      p_re_q <= d_re_q * step_s;
      p_im_q <= d_im_q * step_s;
    end
    if (cmd_i.map_add) begin
      c_re_q <= c_re_d;
      c_im_q <= c_im_d;
      zr_q   <= c_re_d;
      zi_q   <= c_im_d;
    end
    if (cmd_i.iter_mul) begin
      rr_q <= zr_q * zr_q;
      ii_q <= zi_q * zi_q;
      ri_q <= zr_q * zi_q;
    end
    if (cmd_i.iter_eval && !sts_o.stop) begin
      zr_q <= nr;
      zi_q <= ni;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      inside_q <= 1'b0;
    end else if (cmd_i.map_add) begin
      count_q  <= '0;
      inside_q <= 1'b0;
    end else if (cmd_i.iter_eval && !sts_o.stop) begin
      if (sts_o.hit) begin
        inside_q <= 1'b1;
      end else begin
        count_q <= count_q + COUNT_W'(1);
      end
    end
  end

  function automatic logic [23:0] palette(input logic [LIMIT_W-1:0] n);
    logic [8:0] m;
    logic [7:0] r, g, b;
    m = {2'b00, n};
    r = 8'd0;
    g = 8'd0;
    b = 8'd0;
    priority if (n == 7'd0) begin
      r = 8'd255;
    end else if (n < 7'd16) begin
      r = 8'(9'd16 * (9'd16 - m));
      b = 8'(9'd16 * m - 9'd1);
    end else if (n < 7'd32) begin
      g = 8'(9'd16 * (m - 9'd16));
      b = 8'(9'd16 * (9'd32 - m) - 9'd1);
    end else if (n < 7'd64) begin
      r = 8'(9'd8 * (m - 9'd32));
      g = 8'(9'd8 * (9'd64 - m) - 9'd1);
    end else begin
      r = 8'(9'd255 - 9'd4 * (m - 9'd64));
    end
    return {b, g, r};
  endfunction

  logic [23:0] rgb;

  assign in_set = inside_q || (count_q >= {1'b0, cfg_i.iteration_limit});
  assign rgb    = palette(count_q[LIMIT_W-1:0]);

  assign res_o.iter_count = in_set ? '0 : count_q[LIMIT_W-1:0];
  assign res_o.in_set     = in_set;
  assign res_o.red        = in_set ? 8'd0 : rgb[7:0];
  assign res_o.green      = in_set ? 8'd0 : rgb[15:8];
  assign res_o.blue       = in_set ? 8'd0 : rgb[23:16];

endmodule

/* tb/sv/efp_pixel_checker.sv */
`timescale 1ns / 1ps
// Result checker for the escape-time fractal pixel core: follows register writes, predicts
// the escape count, in-set flag and palette color of each accepted pixel, and compares
// the output words in order. Depends on efp_pkg for register indexes and the result layout.
module efp_pixel_checker
  import efp_pkg::*;
#(
  parameter int IMG_WIDTH  = 1000,
  parameter int IMG_HEIGHT = 600,
  parameter int FRAC_BITS  = 28
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              pix_valid_i,
  input  logic              pix_ready_i,
  input  logic [23:0]       pix_data_i,   // pixel_col[11:0], pixel_row[23:12]
  input  logic              res_valid_i,
  input  logic              res_ready_i,
  input  logic [31:0]       res_data_i,   // iter_count, in_set, red, green, blue
  input  logic              cfg_we_i,
  input  logic [IDX_W-1:0]  cfg_idx_i,
  input  logic [WORD_W-1:0] cfg_wdata_i,
  output int                pending_o,
  output int                errors_o
);

  logic [STEP_W-1:0]        step_q;
  logic signed [WORD_W-1:0] off_re_q;
  logic signed [WORD_W-1:0] off_im_q;
  logic [LIMIT_W-1:0]       limit_q;
  efp_res_t                 colours_due[$];
  efp_res_t                 want;
  efp_res_t                 got;

  function automatic longint clamp_word(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // The product is exact; the arithmetic shift halves it with floor.
  function automatic longint plane_coord(logic [PIX_W-1:0] pix, int size,
                                         logic signed [WORD_W-1:0] off);
    longint span;
    span = (2 * longint'(pix) - size) * longint'(step_q);
    return clamp_word((span >>> 1) + longint'(off));
  endfunction

  function automatic bit outside_radius(longint re, longint im);
    longint unsigned a_re;
    longint unsigned a_im;
    if (2 * FRAC_BITS + 2 > 63) return 1'b0;
    a_re = (re < 0) ? -re : re;
    a_im = (im < 0) ? -im : im;
    return (a_re * a_re + a_im * a_im) > (64'd1 << (2 * FRAC_BITS + 2));
  endfunction

  function automatic efp_res_t predict_pixel(logic [PIX_W-1:0] col, logic [PIX_W-1:0] row);
    longint   c_re;
    longint   c_im;
    longint   z_re;
    longint   z_im;
    longint   nxt_re;
    longint   nxt_im;
    int       n;
    bit       member;
    efp_res_t r;
    c_re   = plane_coord(col, IMG_WIDTH, off_re_q);
    c_im   = plane_coord(row, IMG_HEIGHT, off_im_q);
    z_re   = c_re;
    z_im   = c_im;
    n      = 0;
    member = 1'b0;
    while (!member && !outside_radius(z_re, z_im) && n <= limit_q) begin
      nxt_re = clamp_word(((z_re * z_re - z_im * z_im) >>> FRAC_BITS) + c_re);
      nxt_im = clamp_word(((z_re * z_im) >>> (FRAC_BITS - 1)) + c_im);
      z_re   = nxt_re;
      z_im   = nxt_im;
      // An orbit that returns exactly to c is periodic and never escapes.
      if (z_re == c_re && z_im == c_im) begin
        member = 1'b1;
      end else begin
        n++;
      end
    end
    if (n >= limit_q) member = 1'b1;
    r        = '0;
    r.in_set = member;
    if (member) begin
      r.iter_count = '0;
    end else begin
      r.iter_count = n[LIMIT_W-1:0];
      if (n == 0) begin
        r.red = 8'd255;
      end else if (n < 16) begin
        r.red  = 8'(16 * (16 - n));
        r.blue = 8'(16 * n - 1);
      end else if (n < 32) begin
        r.green = 8'(16 * (n - 16));
        r.blue  = 8'(16 * (32 - n) - 1);
      end else if (n < 64) begin
        r.red   = 8'(8 * (n - 32));
        r.green = 8'(8 * (64 - n) - 1);
      end else begin
        r.red = 8'(255 - 4 * (n - 64));
      end
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q    = 31'd1073742;
      off_re_q  = -32'sd187904819;
      off_im_q  = 32'sd0;
      limit_q   = 7'd127;
      colours_due.delete();
      pending_o = 0;
      errors_o  = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_STEP_SIZE:   step_q   = cfg_wdata_i[STEP_W-1:0];
          REG_OFFSET_REAL: off_re_q = cfg_wdata_i;
          REG_OFFSET_IMAG: off_im_q = cfg_wdata_i;
          REG_ITER_LIMIT:  limit_q  = cfg_wdata_i[LIMIT_W-1:0];
          default: ;
        endcase
      end
      if (pix_valid_i && pix_ready_i) begin
        colours_due.push_back(predict_pixel(pix_data_i[11:0], pix_data_i[23:12]));
      end
      if (res_valid_i && res_ready_i) begin
        got = res_data_i;
        if (colours_due.size() == 0) begin
          errors_o++;
          if (errors_o <= 10) $display("result word %h arrived with no pixel pending", got);
        end else begin
          want = colours_due.pop_front();
          if (got.iter_count !== want.iter_count || got.in_set !== want.in_set ||
              got.red !== want.red || got.green !== want.green || got.blue !== want.blue) begin
            errors_o++;
            if (errors_o <= 10) begin
              $display({"pixel mismatch at %0t: want count %0d set %0d rgb %0d/%0d/%0d,",
                        " got count %0d set %0d rgb %0d/%0d/%0d"},
                       $realtime, want.iter_count, want.in_set, want.red, want.green,
                       want.blue, got.iter_count, got.in_set, got.red, got.green, got.blue);
            end
          end
        end
      end
      pending_o = colours_due.size();
    end
  end

endmodule

/* tb/sv/escape_time_fractal_pixel_core_tb.sv */
`timescale 1ns / 1ps
// Testbench top for escape_time_fractal_pixel_core: drives pixel words, register writes and
// random stalls on both streams, and prints the verdict. Depends on efp_pkg and efp_pixel_checker.
module escape_time_fractal_pixel_core_tb;
  import efp_pkg::*;

  localparam int IMG_WIDTH     = 1000;
  localparam int IMG_HEIGHT    = 600;
  localparam int FRAC_BITS     = 28;
  localparam int CYCLE_LIMIT   = 1_500_000;
  localparam int RANDOM_PHASES = 24;
  localparam int QUIET_PHASES  = 3;
  localparam int TAIL_CYCLES   = 300;

  logic              clk_i;
  logic              rst_ni;
  logic              s_axis_tvalid;
  logic              s_axis_tready;
  logic [23:0]       s_axis_tdata;   // pixel_col[11:0], pixel_row[23:12]
  logic              m_axis_tvalid;
  logic              m_axis_tready;
  logic [31:0]       m_axis_tdata;   // iter_count[6:0], in_set[7], red[15:8], green[23:16],
                                     // blue[31:24]
  logic              cfg_we_i;
  logic [IDX_W-1:0]  cfg_idx_i;
  logic [WORD_W-1:0] cfg_wdata_i;
  int                pending;
  int                errors;
  int                cycle_cnt;
  int                ready_left;
  bit                idle_on;

  escape_time_fractal_pixel_core #(
    .IMG_WIDTH (IMG_WIDTH),
    .IMG_HEIGHT(IMG_HEIGHT),
    .FRAC_BITS (FRAC_BITS)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  efp_pixel_checker #(
    .IMG_WIDTH (IMG_WIDTH),
    .IMG_HEIGHT(IMG_HEIGHT),
    .FRAC_BITS (FRAC_BITS)
  ) pixel_check (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .pix_valid_i(s_axis_tvalid),
    .pix_ready_i(s_axis_tready),
    .pix_data_i (s_axis_tdata),
    .res_valid_i(m_axis_tvalid),
    .res_ready_i(m_axis_tready),
    .res_data_i (m_axis_tdata),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .pending_o  (pending),
    .errors_o   (errors)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Output side: random stall bursts between ready stretches, only while idle_on is set.
  always @(negedge clk_i) begin
    if (ready_left == 0) begin
      if (idle_on && $urandom_range(0, 3) == 0) begin
        m_axis_tready <= 1'b0;
        ready_left = $urandom_range(1, 8);
      end else begin
        m_axis_tready <= 1'b1;
        ready_left = $urandom_range(1, 16);
      end
    end
    ready_left--;
  end

  task automatic write_reg(logic [IDX_W-1:0] idx, logic [WORD_W-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    @(negedge clk_i);
  endtask

  task automatic load_config(logic [STEP_W-1:0] step, logic signed [WORD_W-1:0] off_re,
                             logic signed [WORD_W-1:0] off_im, logic [LIMIT_W-1:0] lim);
    write_reg(REG_STEP_SIZE, {1'b0, step});
    write_reg(REG_OFFSET_REAL, off_re);
    write_reg(REG_OFFSET_IMAG, off_im);
    write_reg(REG_ITER_LIMIT, WORD_W'(lim));
    cfg_we_i <= 1'b0;
  endtask

  // Entered and left at a falling edge; the valid stays high into the next word.
  task automatic send_pixel(logic [PIX_W-1:0] col, logic [PIX_W-1:0] row);
    int gap;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 8);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {row, col};
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // Mostly offsets around the set and image-sized steps, so escape counts spread widely.
  task automatic random_config();
    logic [STEP_W-1:0]        step;
    logic signed [WORD_W-1:0] off_re;
    logic signed [WORD_W-1:0] off_im;
    logic [LIMIT_W-1:0]       lim;
    case ($urandom_range(0, 9))
      0:       step = '0;
      1:       step = '1;
      2:       step = STEP_W'($urandom);
      3:       step = STEP_W'($urandom_range(1, 64));
      default: step = STEP_W'($urandom_range(1 << 14, 1 << 21));
    endcase
    case ($urandom_range(0, 7))
      0, 1:    off_re = $urandom;
      2:       off_re = $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
      default: off_re = int'($urandom_range(0, 751619276)) - 590558003;
    endcase
    case ($urandom_range(0, 7))
      0, 1:    off_im = $urandom;
      2:       off_im = $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
      default: off_im = int'($urandom_range(0, 536870912)) - 268435456;
    endcase
    case ($urandom_range(0, 9))
      0:       lim = '0;
      1:       lim = 7'd1;
      2:       lim = 7'd127;
      3:       lim = LIMIT_W'($urandom);
      default: lim = LIMIT_W'($urandom_range(2, 126));
    endcase
    load_config(step, off_re, off_im, lim);
  endtask

  initial begin
    int n_items;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    m_axis_tready = 1'b1;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = REG_STEP_SIZE;
    cfg_wdata_i   = '0;
    idle_on       = 1'b1;
    ready_left    = 0;
    cycle_cnt     = 0;
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Reset settings: corners, center and pixels beyond the image edge.
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd4095, 12'd4095);
    send_pixel(12'd4095, 12'd0);
    send_pixel(12'd0, 12'd4095);
    send_pixel(12'd500, 12'd300);
    send_pixel(12'd999, 12'd599);
    send_pixel(12'd1000, 12'd600);
    send_pixel(12'd350, 12'd300);
    drain_results();

    // A step of 1/256: the center maps to 0 and column 244 to -1, both periodic orbits.
    load_config(31'd1 << 20, 32'sd0, 32'sd0, 7'd127);
    send_pixel(12'd500, 12'd300);
    send_pixel(12'd244, 12'd300);
    send_pixel(12'd500, 12'd44);
    drain_results();

    // Zero step with the offset at 4.0: every pixel escapes before the first step.
    load_config(31'd0, 32'sh4000_0000, 32'sd0, 7'd127);
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd4095, 12'd4095);
    drain_results();

    // Largest step and extreme offsets drive the mapping into saturation.
    load_config('1, 32'sh7FFF_FFFF, 32'sh8000_0000, 7'd1);
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd4095, 12'd4095);
    send_pixel(12'd500, 12'd300);
    drain_results();

    // A zero limit reports every point inside the set.
    load_config(31'd1073742, -32'sd187904819, 32'sd0, 7'd0);
    send_pixel(12'd500, 12'd300);
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd123, 12'd456);
    drain_results();

    // c = -2 sits exactly on the escape radius and stays there.
    load_config(31'd0, 32'shE000_0000, 32'sd0, 7'd5);
    send_pixel(12'd7, 12'd9);
    drain_results();

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      idle_on = (ph < RANDOM_PHASES - QUIET_PHASES);
      random_config();
      n_items = $urandom_range(40, 68);
      for (int k = 0; k < n_items; k++) begin
        if ($urandom_range(0, 4) == 0) begin
          send_pixel(PIX_W'($urandom_range(0, 4095)), PIX_W'($urandom_range(0, 4095)));
        end else begin
          send_pixel(PIX_W'($urandom_range(0, IMG_WIDTH - 1)),
                     PIX_W'($urandom_range(0, IMG_HEIGHT - 1)));
        end
      end
      drain_results();
    end

    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
